FILE: rtl/core/mcog_pkg.sv
// Package for the midpoint circle offset generator.
// Field widths, request kinds and point-group codes; no dependencies.
`timescale 1ns / 1ps

package mcog_pkg;

  localparam int RADIUS_W   = 7;
  localparam int SLOT_W     = 9;
  localparam int OFFSET_W   = 8;
  localparam int TERM_W     = 9;
  localparam int IDX_W      = 3;
  localparam int MAX_RADIUS = 64;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_t;

  // Which group of symmetric points the current octant point yields.
  typedef enum logic [1:0] {
    GRP_NONE = 2'd0,
    GRP_AXIS = 2'd1,
    GRP_DIAG = 2'd2,
    GRP_FULL = 2'd3
  } point_grp_t;

  localparam logic [IDX_W-1:0] LAST_IDX_QUAD = IDX_W'(3);
  localparam logic [IDX_W-1:0] LAST_IDX_OCT  = IDX_W'(7);

endpackage

FILE: rtl/core/midpoint_circle_offset_generator.sv
// Midpoint circle offset generator, top level.
// Depends on mcog_pkg for widths, request kinds and point-group codes.
`timescale 1ns / 1ps

// A start request loads the radius (0 reads as 1, values above 64 saturate)
// and yields the four axis points; each advance request runs one midpoint
// step and yields the four diagonal points or the eight symmetric points of
// the new octant point, each tagged with its slot in a ring of 8*R slots.
// Points leave one per cycle, unless out_tready holds them, from a single
// output register; an advance after the walk has finished yields nothing.
// The next request is taken in the same cycle as the last point of the
// current one is loaded into the output register. out_tlast marks the
// final point of a request, out_tuser is high on every point once the
// octant walk has finished.
module midpoint_circle_offset_generator
  import mcog_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [6:0] radius, [7] zero
  input  logic                  in_tuser,   // [0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [8:0] slot, [16:9] offset_x,
                                            // [24:17] offset_y, [31:25] zero
  output logic                  out_tlast,
  output logic                  out_tuser   // [0] complete
);

  // Walk state
  logic [RADIUS_W-1:0]      ring_radius_r, ring_radius_nxt;
  logic [RADIUS_W-1:0]      walk_x_r, walk_x_nxt;
  logic [RADIUS_W-1:0]      walk_y_r, walk_y_nxt;
  logic signed [TERM_W-1:0] term_r, term_nxt;
  logic                     walking_r, walking_nxt;

  // Point emission
  logic                     busy_r, busy_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]        out_slot_r;
  logic signed [OFFSET_W-1:0] out_x_r, out_y_r;
  logic                     out_last_r, out_done_r;

  logic                     out_load, emit, emit_last, in_fire, stepped;
  logic [RADIUS_W-1:0]      radius_sat;
  point_grp_t               grp;
  logic [IDX_W-1:0]         last_idx;

  logic [SLOT_W-1:0]        r1, r2, r3, r4, r5, r6, r7, dd;
  logic signed [OFFSET_W-1:0] px, py, nx, ny;
  logic [SLOT_W-1:0]        pt_slot;
  logic signed [OFFSET_W-1:0] pt_x, pt_y;

  // Handshake
  assign out_load  = !out_valid_r || out_tready;
  assign emit      = busy_r && out_load;
  assign emit_last = (idx_r == last_idx);
  assign in_tready = !busy_r || (out_load && emit_last);
  assign in_fire   = in_tvalid && in_tready;

  // Walk update
  always_comb begin
    radius_sat = in_tdata[RADIUS_W-1:0];
    if (radius_sat == '0) begin
      radius_sat = RADIUS_W'(1);
    end else if (radius_sat > RADIUS_W'(MAX_RADIUS)) begin
      radius_sat = RADIUS_W'(MAX_RADIUS);
    end

    ring_radius_nxt = ring_radius_r;
    walk_x_nxt      = walk_x_r;
    walk_y_nxt      = walk_y_r;
    term_nxt        = term_r;
    walking_nxt     = walking_r;
    stepped         = 1'b0;

    if (in_fire) begin
      if (kind_t'(in_tuser) == KIND_START) begin
        ring_radius_nxt = radius_sat;
        walk_x_nxt      = radius_sat;
        walk_y_nxt      = '0;
        term_nxt        = -$signed({2'b00, radius_sat});
        walking_nxt     = 1'b1;
        stepped         = 1'b1;
      end else if (walking_r) begin
        stepped = 1'b1;
        if (term_r < 0) begin
          term_nxt   = term_r + $signed({1'b0, walk_y_r, 1'b0}) + TERM_W'(2);
          walk_y_nxt = walk_y_r + RADIUS_W'(1);
        end else begin
          term_nxt   = term_r - $signed({1'b0, walk_x_r, 1'b0}) + TERM_W'(2);
          walk_x_nxt = walk_x_r - RADIUS_W'(1);
        end
      end
      if (stepped && (walk_x_nxt <= walk_y_nxt)) begin
        walking_nxt = 1'b0;
      end
    end
  end

  // Point group of the registered octant point
  always_comb begin
    if (walk_y_r == '0) begin
      grp = GRP_AXIS;
    end else if (walk_y_r == walk_x_r) begin
      grp = GRP_DIAG;
    end else if (walk_y_r < walk_x_r) begin
      grp = GRP_FULL;
    end else begin
      grp = GRP_NONE;
    end
    last_idx = (grp == GRP_FULL) ? LAST_IDX_OCT : LAST_IDX_QUAD;
  end

  // Point selection
  always_comb begin
    r1 = SLOT_W'(ring_radius_r);
    r2 = r1 << 1;
    r4 = r1 << 2;
    r3 = r2 + r1;
    r5 = r4 + r1;
    r6 = r4 + r2;
    r7 = r6 + r1;
    dd = SLOT_W'(walk_x_r - walk_y_r);
    px = $signed({1'b0, walk_x_r});
    py = $signed({1'b0, walk_y_r});
    nx = -px;
    ny = -py;

    pt_slot = '0;
    pt_x    = '0;
    pt_y    = '0;
    case (grp)
      GRP_AXIS: begin
        case (idx_r[1:0])
          2'd0:    begin pt_slot = '0; pt_x = px; pt_y = '0; end
          2'd1:    begin pt_slot = r2; pt_x = '0; pt_y = px; end
          2'd2:    begin pt_slot = r4; pt_x = nx; pt_y = '0; end
          default: begin pt_slot = r6; pt_x = '0; pt_y = nx; end
        endcase
      end
      GRP_DIAG: begin
        case (idx_r[1:0])
          2'd0:    begin pt_slot = r1; pt_x = py; pt_y = py; end
          2'd1:    begin pt_slot = r3; pt_x = ny; pt_y = py; end
          2'd2:    begin pt_slot = r5; pt_x = ny; pt_y = ny; end
          default: begin pt_slot = r7; pt_x = py; pt_y = ny; end
        endcase
      end
      GRP_FULL: begin
        case (idx_r)
          3'd0:    begin pt_slot = r1 - dd; pt_x = px; pt_y = py; end
          3'd1:    begin pt_slot = r1 + dd; pt_x = py; pt_y = px; end
          3'd2:    begin pt_slot = r3 - dd; pt_x = ny; pt_y = px; end
          3'd3:    begin pt_slot = r3 + dd; pt_x = nx; pt_y = py; end
          3'd4:    begin pt_slot = r5 - dd; pt_x = nx; pt_y = ny; end
          3'd5:    begin pt_slot = r5 + dd; pt_x = ny; pt_y = nx; end
          3'd6:    begin pt_slot = r7 - dd; pt_x = py; pt_y = nx; end
          default: begin pt_slot = r7 + dd; pt_x = px; pt_y = ny; end
        endcase
      end
      default: begin
        pt_slot = '0;
      end
    endcase
  end

  // Emission control: a new request takes priority over finishing the old one
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (in_fire) begin
      busy_nxt = stepped && (walk_x_nxt >= walk_y_nxt);
      idx_nxt  = '0;
    end else if (emit) begin
      busy_nxt = !emit_last;
      idx_nxt  = idx_r + IDX_W'(1);
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_radius_r <= '0;
      walk_x_r      <= '0;
      walk_y_r      <= '0;
      term_r        <= '0;
      walking_r     <= 1'b0;
      busy_r        <= 1'b0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      ring_radius_r <= ring_radius_nxt;
      walk_x_r      <= walk_x_nxt;
      walk_y_r      <= walk_y_nxt;
      term_r        <= term_nxt;
      walking_r     <= walking_nxt;
      busy_r        <= busy_nxt;
      idx_r         <= idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_slot_r <= pt_slot;
      out_x_r    <= pt_x;
      out_y_r    <= pt_y;
      out_last_r <= emit_last;
      out_done_r <= !walking_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_y_r, out_x_r, out_slot_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

`ifndef ASSERT_OFF
  a_ready_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !emit_last) |-> !in_tready)
    else $error("request taken while points of the previous one remain");

  a_octant_order: assert property (@(posedge clk) disable iff (!rst_n)
    walk_y_r <= walk_x_r)
    else $error("octant point crossed the diagonal");

  a_busy_has_points: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (grp != GRP_NONE))
    else $error("emitting with no point group");

  a_idle_advance_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser && !walking_r) |=> !busy_r)
    else $error("advance after completion produced points");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last && !in_fire) |=> !busy_r)
    else $error("emission ran past the last point");
`endif

endmodule
